FILE: rtl/core/ovsc_pkg.sv
package ovsc_pkg;

  // field and register widths
  localparam int DUTY_W   = 10;
  localparam int TRAVEL_W = 12;
  localparam int BAND_W   = 10;
  localparam int PERIOD_W = 14;
  localparam int POS_W    = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // arithmetic constants
  localparam int FULL_SCALE  = 1000000;
  localparam int PERMILLE    = 1000;
  localparam int HOME_FACTOR = 1500;
  localparam int MIN_BAND    = 2;

  // step = 1000 * period / travel, restoring divider
  localparam int DIVD_W    = 24;
  localparam int DIV_STEPS = DIVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // reset values of the configuration registers
  localparam logic [TRAVEL_W-1:0] TRAVEL_RST = TRAVEL_W'(60);
  localparam logic [BAND_W-1:0]   BAND_RST   = BAND_W'(10);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    CMD_REST  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } drive_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/ovsc_div.sv
module ovsc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ovsc_pkg::DIVD_W-1:0]       dividend,
  input  logic [ovsc_pkg::TRAVEL_W-1:0]     divisor,
  output logic                              busy,
  output logic [ovsc_pkg::DIVD_W-1:0]       quotient
);

  logic                              busy_r, busy_nxt;
  logic [ovsc_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ovsc_pkg::TRAVEL_W-1:0]     rem_r, rem_nxt;
  logic [ovsc_pkg::TRAVEL_W-1:0]     dsr_r, dsr_nxt;
  logic [ovsc_pkg::DIVD_W-1:0]       quo_r, quo_nxt;
  logic [ovsc_pkg::TRAVEL_W:0]       trial;
  logic                              ge;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[ovsc_pkg::DIVD_W-1]};
    ge       = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? ovsc_pkg::TRAVEL_W'(trial - {1'b0, dsr_r})
                   : trial[ovsc_pkg::TRAVEL_W-1:0];
      quo_nxt = {quo_r[ovsc_pkg::DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ovsc_pkg::DIV_CNT_W'(ovsc_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/ovsc_dp.sv
module ovsc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ovsc_pkg::ctrl_cmd_t                cmd,
  output ovsc_pkg::dp_status_t               status,
  input  logic [ovsc_pkg::DUTY_W-1:0]        in_duty,
  input  logic                               cfg_we,
  input  logic [ovsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ovsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ovsc_pkg::drive_cmd_t               out_cmd,
  output logic                               out_homing
);

  localparam logic [ovsc_pkg::POS_W-1:0] FULL_POS = ovsc_pkg::POS_W'(ovsc_pkg::FULL_SCALE);
  localparam logic [19:0] FULL_20 = 20'(ovsc_pkg::FULL_SCALE);

  logic [ovsc_pkg::TRAVEL_W-1:0] travel_r;
  logic [ovsc_pkg::BAND_W-1:0]   band_r;
  logic [ovsc_pkg::PERIOD_W-1:0] period_r;
  logic [ovsc_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                          homed_r, homed_nxt;
  logic [ovsc_pkg::DUTY_W-1:0]   duty_r;
  ovsc_pkg::drive_cmd_t          cmd_r, cmd_nxt;
  logic                          hom_r, hom_nxt;

  logic [ovsc_pkg::TRAVEL_W-1:0] travel_eff;
  logic [ovsc_pkg::DIVD_W-1:0]   dividend;
  logic [ovsc_pkg::DIVD_W-1:0]   step;
  logic                          div_busy;

  logic [26:0]                   home_cnt;
  logic [22:0]                   home_thr;
  logic                          home_end;

  logic [ovsc_pkg::BAND_W-1:0]   band;
  logic [10:0]                   dpb, dmb1;
  logic                          lo_ok;
  logic [20:0]                   lo_thr, hi_thr;
  logic [19:0]                   posc;
  logic                          want_open, want_close;
  logic [24:0]                   pos_up;
  logic [19:0]                   pos_run;
  ovsc_pkg::drive_cmd_t          run_cmd;

  // step size divider, started on each accepted item
  assign travel_eff = (travel_r == '0) ? ovsc_pkg::TRAVEL_W'(1) : travel_r;
  assign dividend   = ovsc_pkg::DIVD_W'(period_r) * ovsc_pkg::DIVD_W'(ovsc_pkg::PERMILLE);

  ovsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (dividend),
    .divisor  (travel_eff),
    .busy     (div_busy),
    .quotient (step)
  );

  assign status.div_busy = div_busy;

  // homing counter
  assign home_cnt = 27'(pos_r) + 27'(period_r);
  assign home_thr = 23'(travel_eff) * 23'(ovsc_pkg::HOME_FACTOR);
  assign home_end = home_cnt > 27'(home_thr);

  // per-mille compare without division: floor(pos/1000) <= k iff pos < (k+1)*1000
  always_comb begin
    band = (band_r < ovsc_pkg::BAND_W'(ovsc_pkg::MIN_BAND))
           ? ovsc_pkg::BAND_W'(ovsc_pkg::MIN_BAND) : band_r;
    posc = (pos_r > FULL_POS) ? FULL_20 : pos_r[19:0];
    dpb  = 11'(duty_r) + 11'(band);
    lo_ok = duty_r >= band;
    dmb1 = 11'(duty_r) - 11'(band) + 11'd1;
    lo_thr = 21'(dmb1) * 21'(ovsc_pkg::PERMILLE);
    hi_thr = 21'(dpb) * 21'(ovsc_pkg::PERMILLE);
    want_open  = lo_ok && (21'(posc) < lo_thr);
    want_close = 21'(posc) >= hi_thr;
  end

  // running command and position move
  always_comb begin
    pos_up  = 25'(posc) + 25'(step);
    pos_run = posc;
    run_cmd = ovsc_pkg::CMD_REST;
    priority if (want_open) begin
      run_cmd = ovsc_pkg::CMD_OPEN;
      pos_run = (pos_up > 25'(FULL_20)) ? FULL_20 : pos_up[19:0];
    end else if (want_close) begin
      run_cmd = ovsc_pkg::CMD_CLOSE;
      pos_run = (24'(posc) < step) ? '0 : posc - step[19:0];
    end
    // forcing near the ends of the demand range, close wins
    if (dpb >= 11'(ovsc_pkg::PERMILLE)) begin
      run_cmd = ovsc_pkg::CMD_OPEN;
    end
    if (duty_r <= band) begin
      run_cmd = ovsc_pkg::CMD_CLOSE;
    end
  end

  // state update on commit
  always_comb begin
    pos_nxt   = pos_r;
    homed_nxt = homed_r;
    cmd_nxt   = cmd_r;
    hom_nxt   = hom_r;
    if (cmd.commit) begin
      if (!homed_r) begin
        pos_nxt   = home_end ? '0 : home_cnt[ovsc_pkg::POS_W-1:0];
        homed_nxt = home_end;
        cmd_nxt   = ovsc_pkg::CMD_CLOSE;
        hom_nxt   = 1'b1;
      end else begin
        pos_nxt = ovsc_pkg::POS_W'(pos_run);
        cmd_nxt = run_cmd;
        hom_nxt = 1'b0;
      end
    end
  end

  // configuration and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r <= ovsc_pkg::TRAVEL_RST;
      band_r   <= ovsc_pkg::BAND_RST;
      period_r <= ovsc_pkg::PERIOD_RST;
      pos_r    <= '0;
      homed_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          ovsc_pkg::CFG_TRAVEL: travel_r <= cfg_wdata[ovsc_pkg::TRAVEL_W-1:0];
          ovsc_pkg::CFG_BAND:   band_r   <= cfg_wdata[ovsc_pkg::BAND_W-1:0];
          ovsc_pkg::CFG_PERIOD: period_r <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r   <= pos_nxt;
      homed_r <= homed_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      duty_r <= in_duty;
    end
    cmd_r <= cmd_nxt;
    hom_r <= hom_nxt;
  end

  assign out_cmd    = cmd_r;
  assign out_homing = hom_r;

  // once homed, the position model stays inside full scale
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    homed_r |-> pos_r <= FULL_POS)
    else $error("position model beyond full scale");

  // homing ends with the model at zero
  a_home_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(homed_r) |-> pos_r == '0)
    else $error("homing ended with nonzero position");

  // running phase never goes back to homing
  a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    homed_r |=> homed_r)
    else $error("homed flag cleared without reset");

  // a result is only written after the step size is ready
  a_commit_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !div_busy)
    else $error("commit while divider busy");

endmodule

FILE: rtl/core/ovsc_ctrl.sv
module ovsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ovsc_pkg::ctrl_cmd_t  cmd,
  input  ovsc_pkg::dp_status_t status
);

  ovsc_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // next state, handshakes and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      ovsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ovsc_pkg::ST_DIV;
        end
      end
      ovsc_pkg::ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ovsc_pkg::ST_WRITE;
        end
      end
      ovsc_pkg::ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ovsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ovsc_pkg::ST_IDLE;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  // an accepted item always starts the divider phase
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ovsc_pkg::ST_DIV && status.div_busy))
    else $error("accepted item did not start divider");

  // writeback only sees a finished step size
  a_write_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ovsc_pkg::ST_WRITE |-> !status.div_busy)
    else $error("writeback with divider busy");

endmodule

FILE: rtl/core/open_loop_valve_step_controller.sv
// channel  | ports                        | fields (low bit up)
// ---------+------------------------------+-----------------------------------
// input    | in_tvalid in_tready in_tdata | [9:0] duty_demand, [15:10] zero
// result   | out_tvalid out_tready        | tdata [1:0] drive_cmd, [7:2] zero;
//          | out_tdata out_tuser          | tuser [0] homing
// config   | cfg_valid cfg_ready          | cfg_index: 0 travel_time_s,
//          | cfg_index cfg_data           | 1 dead_band, 2 sample_period_ms
//
// per item: accept, divider run, divider-done check, then writeback, which waits
// until any pending result is taken; only then is the next item accepted.
// one item is in work at a time; the result register lets the next item in
// while the previous result waits for out_tready.
// rst_n is synchronous: homing restarts, registers return to 60 / 10 / 100.
// cfg_ready is always high; writes to index 3 are ignored.
module open_loop_valve_step_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [9:0] duty_demand
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [1:0] drive_cmd
  output logic                               out_tuser,  // [0] homing
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ovsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ovsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ovsc_pkg::ctrl_cmd_t  cmd;
  ovsc_pkg::dp_status_t status;
  ovsc_pkg::drive_cmd_t drive_cmd;

  assign cfg_ready = 1'b1;

  // sequencing and handshakes
  ovsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // position model, step divider and command logic
  ovsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_duty    (in_tdata[ovsc_pkg::DUTY_W-1:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_cmd    (drive_cmd),
    .out_homing (out_tuser)
  );

  assign out_tdata = {6'b0, drive_cmd};

endmodule
